>>> rtl/artt_pkg.sv
// Package for the anchor range table with two-anchor trilateration.
// Types and constants shared by the controller, datapath and top level.
package artt_pkg;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_DELETE = 2'd1,
      OP_UPDATE = 2'd2,
      OP_SOLVE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL     = 3'd2,
      ST_FEW      = 3'd3,
      ST_NO_ISECT = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SEARCH,
      S_DISPATCH,
      S_SHIFT,
      S_UPD_RD,
      S_UPD_WR,
      S_SLV_RD,
      S_SLV_SQ,
      S_SLV_DIV,
      S_SLV_SQRT,
      S_DONE
   } state_type;

   // Commands from controller to datapath.
   typedef struct packed {
      logic load;        // capture the request
      logic srch_start;  // reset search index
      logic srch_step;   // advance search index
      logic add_wr;      // append entry
      logic shift_step;  // move entry idx+1 into idx
      logic shift_start; // start shift at match index
      logic cnt_dec;
      logic rd_upd;      // read matched entry
      logic div_start;   // start divider
      logic upd_wr;      // write smoothed range
      logic rd_slv;      // read first/last entries
      logic sq_calc;     // form numerator and denominator
      logic sqrt_start;
      logic set_ok;
      logic set_nf;
      logic set_full;
      logic set_few;
      logic finish_solve;
   } cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic [1:0] op;
      logic       addr_zero;
      logic       srch_hit;
      logic       srch_end;
      logic       full;
      logic       few;
      logic       shift_end;
      logic       div_busy;
      logic       sqrt_busy;
   } sts_type;

   localparam int unsigned DivW  = 34;
   localparam int unsigned SqrtW = 32;

endpackage

>>> rtl/artt_if.sv
// Valid/ready channel interfaces for the anchor range table.
// Depends on nothing.
interface artt_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [15:0] node_addr;
   logic [15:0] range_sample;
   modport source (output valid, operation, node_addr, range_sample, input ready);
   modport sink   (input valid, operation, node_addr, range_sample, output ready);
endinterface

interface artt_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         status;
   logic signed [15:0] coord_x;
   logic [15:0]        coord_y;
   modport source (output valid, status, coord_x, coord_y, input ready);
   modport sink   (input valid, status, coord_x, coord_y, output ready);
endinterface

interface artt_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

>>> rtl/artt_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on artt_pkg for widths.
module artt_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [artt_pkg::DivW-1:0]     dividend,
   input  logic [artt_pkg::DivW-1:0]     divisor,
   output logic                          busy,
   output logic [artt_pkg::DivW-1:0]     quotient
);
   localparam int unsigned W  = artt_pkg::DivW;
   localparam int unsigned CW = $clog2(W + 1);

   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  dsr_ff, dsr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]    trial;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      cnt_in = cnt_ff;
      trial  = {rem_ff, quo_ff[W-1]};
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = CW'(W);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = W'(trial - {1'b0, dsr_ff});
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;
endmodule

>>> rtl/artt_sqrt.sv
// Bit-pair integer square root, one result bit per cycle.
// Depends on artt_pkg for widths.
module artt_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [artt_pkg::SqrtW-1:0]    radicand,
   output logic                          busy,
   output logic [artt_pkg::SqrtW/2-1:0]  root
);
   localparam int unsigned W  = artt_pkg::SqrtW;
   localparam int unsigned H  = W / 2;
   localparam int unsigned CW = $clog2(H + 1);

   logic [W-1:0]  rad_ff, rad_in;
   logic [H+1:0]  rem_ff, rem_in;
   logic [H-1:0]  root_ff, root_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [H+1:0]  tr, tst;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      tr  = {rem_ff[H-1:0], rad_ff[W-1:W-2]};
      tst = {root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CW'(H);
      end else if (cnt_ff != '0) begin
         rad_in = {rad_ff[W-3:0], 2'b00};
         if (tr >= tst) begin
            rem_in  = tr - tst;
            root_in = {root_ff[H-2:0], 1'b1};
         end else begin
            rem_in  = tr;
            root_in = {root_ff[H-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = (cnt_ff != '0);
   assign root = root_ff;
endmodule

>>> rtl/artt_datapath.sv
// Datapath: anchor table, search index, smoothing and solve arithmetic.
// Depends on artt_pkg, artt_div and artt_sqrt.
module artt_datapath #(
   parameter int unsigned MAX_ANCHORS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  artt_pkg::cmd_type    cmd,
   output artt_pkg::sts_type    sts,
   input  logic [1:0]           req_operation,
   input  logic [15:0]          req_node_addr,
   input  logic [15:0]          req_range_sample,
   input  logic [15:0]          baseline,
   output logic [2:0]           res_status,
   output logic signed [15:0]   res_x,
   output logic [15:0]          res_y
);
   localparam int unsigned IW = $clog2(MAX_ANCHORS);
   localparam int unsigned CW = $clog2(MAX_ANCHORS + 1);
   localparam int unsigned DW = artt_pkg::DivW;

   logic [15:0] addr_mem [MAX_ANCHORS];
   logic [15:0] lat_mem  [MAX_ANCHORS];
   logic [15:0] prv_mem  [MAX_ANCHORS];

   logic [1:0]  op_ff;
   logic [15:0] addr_ff, smp_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [15:0] rd_addr_ff, rd_lat_ff, rd_prv_ff;
   logic [15:0] a_ff, b_ff;
   logic [17:0] sum_ff;
   logic [37:0] third_prod;
   logic [15:0] third;
   logic        neg_ff;
   logic [DW-1:0] dvd_ff, dsr_ff;
   logic [2:0]  st_ff;
   logic signed [15:0] x_ff;
   logic [15:0] y_ff;
   logic [15:0] c;
   logic        div_busy, sqrt_busy;
   logic [DW-1:0] quo;
   logic [15:0] root;
   logic [31:0] rad_ff;
   logic [IW-1:0] ridx;
   logic [IW-1:0] widx;
   logic signed [34:0] num;
   logic        big;
   logic signed [15:0] xsat;
   logic        sq_go_ff;

   assign c = (baseline == 16'd0) ? 16'd1 : baseline;
   assign ridx = idx_ff[IW-1:0];

   // counter and index
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.add_wr) cnt_in = cnt_ff + 1'b1;
      if (cmd.cnt_dec) cnt_in = cnt_ff - 1'b1;
      if (cmd.srch_start) idx_in = '0;
      if (cmd.srch_step || cmd.shift_step) idx_in = idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      idx_ff <= idx_in;
   end

   // sum / 3 by reciprocal multiply, exact for sums below 2^21
   assign third_prod = 38'(sum_ff) * 38'(20'd699051);
   assign third      = third_prod[36:21];

   // table memory; reads registered
   assign widx = cmd.add_wr ? cnt_ff[IW-1:0] : ridx;
   always_ff @(posedge clock) begin
      if (cmd.add_wr) begin
         addr_mem[widx] <= addr_ff;
         lat_mem[widx]  <= 16'd0;
         prv_mem[widx]  <= 16'd0;
      end else if (cmd.shift_step) begin
         addr_mem[widx] <= rd_addr_ff;
         lat_mem[widx]  <= rd_lat_ff;
         prv_mem[widx]  <= rd_prv_ff;
      end else if (cmd.upd_wr) begin
         prv_mem[widx] <= rd_lat_ff;
         lat_mem[widx] <= third;
      end
   end

   // read port: search/update use idx, shift reads idx+1, solve reads first/last
   always_ff @(posedge clock) begin
      if (cmd.rd_slv) begin
         a_ff <= lat_mem[0];
         b_ff <= lat_mem[IW'(cnt_ff - 1'b1)];
      end else if (cmd.shift_start || cmd.shift_step) begin
         rd_addr_ff <= addr_mem[IW'(idx_in + 1'b1)];
         rd_lat_ff  <= lat_mem[IW'(idx_in + 1'b1)];
         rd_prv_ff  <= prv_mem[IW'(idx_in + 1'b1)];
      end else begin
         rd_addr_ff <= addr_mem[IW'(idx_in)];
         rd_lat_ff  <= lat_mem[IW'(idx_in)];
         rd_prv_ff  <= prv_mem[IW'(idx_in)];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_operation;
         addr_ff <= req_node_addr;
         smp_ff  <= req_range_sample;
      end
      if (cmd.rd_upd) sum_ff <= 18'(smp_ff) + 18'(rd_lat_ff) + 18'(rd_prv_ff);
   end

   // solve: numerator b^2+c^2-a^2 is signed, divide magnitude by 2c
   assign num = 35'(33'(b_ff) * 33'(b_ff)) + 35'(33'(c) * 33'(c))
              - 35'(33'(a_ff) * 33'(a_ff));
   always_ff @(posedge clock) begin
      if (cmd.sq_calc) begin
         neg_ff <= num[34];
         dvd_ff <= num[34] ? DW'(-num) : DW'(num);
         dsr_ff <= DW'({c, 1'b0});
      end
   end

   artt_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(dvd_ff), .divisor(dsr_ff), .busy(div_busy), .quotient(quo)
   );

   // after division: magnitude |x| is quo
   assign big = (quo > DW'(b_ff));
   always_comb begin
      if (neg_ff) xsat = (quo > DW'(32768)) ? -16'sd32768 : 16'(-quo);
      else        xsat = (quo > DW'(32767)) ? 16'sd32767 : 16'(quo);
   end
   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) rad_ff <= 32'(b_ff) * 32'(b_ff) - 32'(quo[15:0]) * 32'(quo[15:0]);
   end

   // root unit starts the cycle after the radicand is registered
   always_ff @(posedge clock) begin
      if (reset) sq_go_ff <= 1'b0;
      else       sq_go_ff <= cmd.sqrt_start;
   end

   artt_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_go_ff),
      .radicand(rad_ff), .busy(sqrt_busy), .root(root)
   );

   // result register
   always_ff @(posedge clock) begin
      if (cmd.set_ok)   begin st_ff <= artt_pkg::ST_OK;        x_ff <= '0; y_ff <= '0; end
      if (cmd.set_nf)   begin st_ff <= artt_pkg::ST_NOT_FOUND; x_ff <= '0; y_ff <= '0; end
      if (cmd.set_full) begin st_ff <= artt_pkg::ST_FULL;      x_ff <= '0; y_ff <= '0; end
      if (cmd.set_few)  begin st_ff <= artt_pkg::ST_FEW;       x_ff <= '0; y_ff <= '0; end
      if (cmd.sqrt_start) begin
         x_ff  <= xsat;
         st_ff <= big ? artt_pkg::ST_NO_ISECT : artt_pkg::ST_OK;
      end
      if (cmd.finish_solve) y_ff <= (st_ff == artt_pkg::ST_NO_ISECT) ? 16'd0 : root;
   end

   assign sts.op        = op_ff;
   assign sts.addr_zero = (addr_ff == 16'd0);
   assign sts.srch_hit  = (rd_addr_ff == addr_ff);
   assign sts.srch_end  = (idx_ff >= cnt_ff);
   assign sts.full      = (cnt_ff >= CW'(MAX_ANCHORS));
   assign sts.few       = (cnt_ff < CW'(2));
   assign sts.shift_end = (CW'(idx_ff + 1'b1) >= cnt_ff);
   assign sts.div_busy  = div_busy;
   assign sts.sqrt_busy = sqrt_busy || sq_go_ff;

   assign res_status = st_ff;
   assign res_x      = x_ff;
   assign res_y      = y_ff;
endmodule

>>> rtl/artt_ctrl.sv
// Controller state machine for the anchor range table.
// Depends on artt_pkg.
module artt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output artt_pkg::cmd_type cmd,
   input  artt_pkg::sts_type sts
);
   artt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= artt_pkg::S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         artt_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cmd.srch_start = 1'b1;
               state_in = artt_pkg::S_DISPATCH;
            end
         end
         artt_pkg::S_DISPATCH: begin
            case (sts.op)
               artt_pkg::OP_ADD: begin
                  if (sts.full) cmd.set_full = 1'b1;
                  else begin cmd.add_wr = 1'b1; cmd.set_ok = 1'b1; end
                  state_in = artt_pkg::S_DONE;
               end
               artt_pkg::OP_SOLVE: begin
                  if (sts.few) begin
                     cmd.set_few = 1'b1;
                     state_in = artt_pkg::S_DONE;
                  end else begin
                     cmd.rd_slv = 1'b1;
                     state_in = artt_pkg::S_SLV_SQ;
                  end
               end
               default: begin
                  if (sts.addr_zero) begin
                     cmd.set_nf = 1'b1;
                     state_in = artt_pkg::S_DONE;
                  end else state_in = artt_pkg::S_SEARCH;
               end
            endcase
         end
         artt_pkg::S_SEARCH: begin
            // rd_addr_ff holds entry idx
            if (sts.srch_end) begin
               cmd.set_nf = 1'b1;
               state_in = artt_pkg::S_DONE;
            end else if (sts.srch_hit) begin
               if (sts.op == artt_pkg::OP_DELETE) begin
                  cmd.shift_start = 1'b1;
                  state_in = artt_pkg::S_SHIFT;
               end else begin
                  state_in = artt_pkg::S_UPD_RD;
               end
            end else cmd.srch_step = 1'b1;
         end
         artt_pkg::S_SHIFT: begin
            if (sts.shift_end) begin
               cmd.cnt_dec = 1'b1;
               cmd.set_ok = 1'b1;
               state_in = artt_pkg::S_DONE;
            end else cmd.shift_step = 1'b1;
         end
         artt_pkg::S_UPD_RD: begin
            cmd.rd_upd = 1'b1;
            state_in = artt_pkg::S_UPD_WR;
         end
         artt_pkg::S_UPD_WR: begin
            cmd.upd_wr = 1'b1;
            cmd.set_ok = 1'b1;
            state_in = artt_pkg::S_DONE;
         end
         artt_pkg::S_SLV_SQ: begin
            cmd.sq_calc = 1'b1;
            state_in = artt_pkg::S_SLV_RD;
         end
         artt_pkg::S_SLV_RD: begin
            cmd.div_start = 1'b1;
            state_in = artt_pkg::S_SLV_DIV;
         end
         artt_pkg::S_SLV_DIV: begin
            if (!sts.div_busy) begin
               cmd.sqrt_start = 1'b1;
               state_in = artt_pkg::S_SLV_SQRT;
            end
         end
         artt_pkg::S_SLV_SQRT: begin
            if (!sts.sqrt_busy) begin
               cmd.finish_solve = 1'b1;
               state_in = artt_pkg::S_DONE;
            end
         end
         artt_pkg::S_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = artt_pkg::S_IDLE;
         end
         default: state_in = artt_pkg::S_IDLE;
      endcase
   end
endmodule

>>> rtl/anchor_range_table_trilateration.sv
// Top level: anchor range table with two-anchor trilateration.
// Depends on artt_pkg, artt_if, artt_ctrl and artt_datapath.
//
//   channel  dir  payload
//   req      in   operation, node_addr, range_sample
//   rsp      out  status, coord_x, coord_y
//   csr      in   baseline (always ready)
//
// One request at a time. Delete and update search the table entry by entry, and
// a delete then shifts the later entries down; add needs no search. A solve
// divides and then takes a square root.
// Reset clears the entry count and the controller. A stalled response holds
// the block; the next request is taken once the response is accepted.
module anchor_range_table_trilateration #(
   parameter int unsigned MAX_ANCHORS = 8
) (
   input  logic        clock,
   input  logic        reset,
   artt_req_if.sink    req,
   artt_rsp_if.source  rsp,
   artt_csr_if.sink    csr
);
   artt_pkg::cmd_type cmd;
   artt_pkg::sts_type sts;
   logic [15:0] baseline_ff;
   logic [2:0]  st;
   logic signed [15:0] cx;
   logic [15:0] cy;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) baseline_ff <= 16'd768;
      else if (csr.valid) baseline_ff <= csr.data;
   end

   artt_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd(cmd), .sts(sts)
   );

   artt_datapath #(.MAX_ANCHORS(MAX_ANCHORS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req_operation(req.operation), .req_node_addr(req.node_addr),
      .req_range_sample(req.range_sample), .baseline(baseline_ff),
      .res_status(st), .res_x(cx), .res_y(cy)
   );

   assign rsp.status  = st;
   assign rsp.coord_x = cx;
   assign rsp.coord_y = cy;
endmodule
